### rtl/ndpp_pkg.sv
// Package for the nibble-direction parallel port unit.
// Holds widths, access and error codes, the result record and the enable helper.
// No dependencies.
package ndpp_pkg;

  localparam int unsigned NumPorts  = 3;
  localparam int unsigned DirW      = 2 * NumPorts;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned InUserW   = 4;
  localparam int unsigned OutDataW  = 64;

  typedef enum logic [1:0] {
    ACT_READ_DATA  = 2'd0,
    ACT_WRITE_DATA = 2'd1,
    ACT_READ_CTRL  = 2'd2,
    ACT_WRITE_CTRL = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_FORM  = 2'd1,
    ERR_DIR_HIGH  = 2'd2
  } error_e;

  // Top two bits of a control write select its form.
  typedef enum logic [1:0] {
    FORM_LOAD_DIR = 2'b00,
    FORM_BAD_LO   = 2'b01,
    FORM_BAD_HI   = 2'b10,
    FORM_BIT_OP   = 2'b11
  } form_e;

  localparam logic [1:0] TargetDir = 2'd3;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t        read_value;
    logic [2:0]   update_mask;
    byte_t [2:0]  drive_value;
    byte_t [2:0]  drive_enable;
    error_e       error_code;
  } result_t;

  // Output-enable mask from the two direction bits of one port.
  function automatic byte_t enable_of(input logic [1:0] d);
    enable_of = {{4{d[1]}}, {4{d[0]}}};
  endfunction

endpackage

### rtl/ndpp_regs.sv
// APB register file for the per-port float levels.
// Depends on ndpp_pkg.
module ndpp_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ndpp_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ndpp_pkg::byte_t [2:0]         float_value_o
);
  import ndpp_pkg::*;

  byte_t [2:0] float_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      float_q <= '0;
    end else if (wr_en && (reg_idx != 2'd3)) begin
      float_q[reg_idx] <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx != 2'd3) begin
      prdata = {24'd0, float_q[reg_idx]};
    end
  end

  assign float_value_o = float_q;

endmodule

### rtl/ndpp_core.sv
// Port state (latches, direction register) and the per-access update logic.
// Depends on ndpp_pkg.
module ndpp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  ndpp_pkg::action_e     action_i,
  input  logic [1:0]            port_index_i,
  input  ndpp_pkg::byte_t       write_value_i,
  input  ndpp_pkg::byte_t       pin_value_i,
  input  ndpp_pkg::byte_t [2:0] float_value_i,
  output ndpp_pkg::result_t     result_o
);
  import ndpp_pkg::*;

  byte_t [2:0]     latch_q, latch_d;
  logic [DirW-1:0] dir_q, dir_d;

  logic [1:0] sel;
  byte_t      sel_latch, sel_en, new_latch;
  logic [2:0] bit_b;
  logic [1:0] tgt;
  logic       bit_v;
  logic [7:0] dir_ext;
  logic [DirW-1:0] diff;
  byte_t      rd;
  logic [2:0] upd;
  error_e     err;

  assign tgt   = write_value_i[5:4];
  assign bit_b = write_value_i[3:1];
  assign bit_v = write_value_i[0];
  assign sel   = (action_i == ACT_WRITE_CTRL) ? tgt : port_index_i;
  // One latch read port, addressed by data port or bit-op target.
  assign sel_latch = (sel == 2'd3) ? 8'd0 : latch_q[sel];
  assign dir_ext   = {2'b00, dir_q};
  assign sel_en    = enable_of(dir_ext[{sel, 1'b0} +: 2]);
  assign new_latch = sel_latch ^ (8'd1 << bit_b);
  assign diff      = write_value_i[DirW-1:0] ^ dir_q;

  always_comb begin
    latch_d = latch_q;
    dir_d   = dir_q;
    rd      = '0;
    upd     = '0;
    err     = ERR_NONE;
    case (action_i)
      ACT_READ_DATA: begin
        if (port_index_i != 2'd3) begin
          rd = (sel_latch & sel_en) | (pin_value_i & ~sel_en);
        end
      end
      ACT_WRITE_DATA: begin
        if (port_index_i != 2'd3) begin
          latch_d[port_index_i] = write_value_i;
          if (((sel_latch ^ write_value_i) & sel_en) != 8'd0) begin
            upd[port_index_i] = 1'b1;
          end
        end
      end
      ACT_READ_CTRL: begin
        rd = dir_ext;
      end
      default: begin
        case (form_e'(write_value_i[7:6]))
          FORM_BIT_OP: begin
            if (tgt != TargetDir) begin
              if (sel_latch[bit_b] != bit_v) begin
                latch_d[tgt] = new_latch;
                if (dir_ext[{tgt, bit_b[2]}]) upd[tgt] = 1'b1;
              end
            end else if (write_value_i[3:2] == 2'b11 && bit_v) begin
              err = ERR_DIR_HIGH;
            end else if (bit_b < 3'd6 && dir_ext[bit_b] != bit_v) begin
              dir_d = dir_q ^ (DirW'(1) << bit_b);
              upd[bit_b[2:1]] = 1'b1;
            end
          end
          FORM_LOAD_DIR: begin
            dir_d  = write_value_i[DirW-1:0];
            upd[0] = |diff[1:0];
            upd[1] = |diff[3:2];
            upd[2] = |diff[5:4];
          end
          default: begin
            err = ERR_BAD_FORM;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      dir_q   <= '0;
    end else if (take_i) begin
      latch_q <= latch_d;
      dir_q   <= dir_d;
    end
  end

  // Drive values reflect the state after this access.
  always_comb begin
    result_o.read_value  = rd;
    result_o.update_mask = upd;
    result_o.error_code  = err;
    for (int n = 0; n < NumPorts; n++) begin
      result_o.drive_enable[n] = enable_of(dir_d[2*n +: 2]);
      result_o.drive_value[n]  = (latch_d[n] & result_o.drive_enable[n]) |
                                 (float_value_i[n] & ~result_o.drive_enable[n]);
    end
  end

endmodule

### rtl/nibble_direction_parallel_port_unit.sv
// Nibble-direction parallel port unit: three 8-bit ports, one shared direction register.
// Latency: a result is valid the cycle after its access transfer; throughput one access per
// cycle unless stalled, set by the single result register between the update logic and the
// output stream. Reset (rst_ni low, asynchronous): latches, directions and float levels go
// to zero, the result register empties. Depends on ndpp_pkg, ndpp_regs, ndpp_core.
module nibble_direction_parallel_port_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ndpp_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Access stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] write_value, [15:8] pin_value
  input  logic [ndpp_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] action, [3:2] port_index
  input  logic [ndpp_pkg::InUserW-1:0]  s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] read_value, [10:8] update_mask, [18:11] drive_value_0, [26:19] drive_enable_0,
  // [34:27] drive_value_1, [42:35] drive_enable_1, [50:43] drive_value_2,
  // [58:51] drive_enable_2, [60:59] error_code, [63:61] zero
  output logic [ndpp_pkg::OutDataW-1:0] m_axis_tdata
);
  import ndpp_pkg::*;

  byte_t [2:0] float_value;
  result_t     res;
  result_t     res_q;
  logic        out_valid_q;
  logic        take;

  ndpp_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .float_value_o (float_value)
  );

  // Accept a new access whenever the result register is empty or drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  ndpp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .action_i      (action_e'(s_axis_tuser[1:0])),
    .port_index_i  (s_axis_tuser[3:2]),
    .write_value_i (s_axis_tdata[7:0]),
    .pin_value_i   (s_axis_tdata[15:8]),
    .float_value_i (float_value),
    .result_o      (res)
  );

  // Result register: advance on a transfer in, drop valid when taken with nothing new.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, res_q.error_code,
                          res_q.drive_enable[2], res_q.drive_value[2],
                          res_q.drive_enable[1], res_q.drive_value[1],
                          res_q.drive_enable[0], res_q.drive_value[0],
                          res_q.update_mask, res_q.read_value};

  // An access that reports an error changes nothing, so it refreshes no port.
  a_err_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.error_code != ERR_NONE) |-> (res_q.update_mask == 3'd0))
    else $error("error access reported a refreshed port");

  // Undriven pins of every port show the float level.
  a_float_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      ((res_q.drive_value[0] & ~res_q.drive_enable[0]) ==
       (float_value[0] & ~res_q.drive_enable[0])) &&
      ((res_q.drive_value[1] & ~res_q.drive_enable[1]) ==
       (float_value[1] & ~res_q.drive_enable[1])) &&
      ((res_q.drive_value[2] & ~res_q.drive_enable[2]) ==
       (float_value[2] & ~res_q.drive_enable[2])))
    else $error("undriven pins do not show the float level");

  // An empty result register never blocks the access stream.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // A stalled result is neither lost nor overwritten.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

endmodule

### tb/tb.sv
// Self-checking testbench for nibble_direction_parallel_port_unit.
// Predicts every access result from a local model of latches, directions and
// float levels and checks the result stream. Depends on ndpp_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import ndpp_pkg::*;

  localparam int unsigned RegFloat0     = 0;    // float level of port n is register n
  localparam int unsigned RegStride     = 4;    // byte stride between registers
  localparam logic [1:0]  NoPort        = 2'd3; // port index with no port behind it
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 4;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [CfgAddrW-1:0] paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [7:0] write_value, [15:8] pin_value
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // [1:0] action, [3:2] port_index
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [7:0] read_value, [10:8] update_mask, then per port n at 11+16n: drive_value_n,
  // drive_enable_n; [60:59] error_code
  logic [OutDataW-1:0] m_axis_tdata;

  nibble_direction_parallel_port_unit dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Local copy of the block's state, advanced once per accepted access.
  byte_t       port_latch [NumPorts];
  logic [5:0]  dir_bits;
  byte_t       float_level [NumPorts];

  result_t     expected_access_results [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned accesses_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          hold_request;

  // Output-enable mask of one port from its two direction bits.
  function automatic byte_t nibble_mask(input int unsigned n);
    nibble_mask = {{4{dir_bits[2*n+1]}}, {4{dir_bits[2*n]}}};
  endfunction

  // Apply one access to the local state and return the result it must produce.
  function automatic result_t predict_port_access(input action_e act, input logic [1:0] port,
                                                  input byte_t wv, input byte_t pins);
    result_t     r;
    byte_t       en;
    byte_t       old;
    int unsigned bit_sel;
    int unsigned tgt;
    logic [5:0]  diff;
    r = '0;
    case (act)
      ACT_READ_DATA: begin
        if (port != NoPort) begin
          en = nibble_mask(port);
          r.read_value = (port_latch[port] & en) | (pins & ~en);
        end
      end
      ACT_WRITE_DATA: begin
        if (port != NoPort) begin
          old = port_latch[port];
          port_latch[port] = wv;
          if (((old ^ wv) & nibble_mask(port)) != 0) r.update_mask[port] = 1'b1;
        end
      end
      ACT_READ_CTRL: r.read_value = {2'b00, dir_bits};
      ACT_WRITE_CTRL: begin
        bit_sel = wv[3:1];
        tgt     = wv[5:4];
        case (form_e'(wv[7:6]))
          FORM_BIT_OP: begin
            if (tgt != TargetDir) begin
              // Single latch bit; refresh only if its nibble is driven.
              if (port_latch[tgt][bit_sel] != wv[0]) begin
                port_latch[tgt][bit_sel] = wv[0];
                if (dir_bits[2*tgt + (bit_sel >= 4)]) r.update_mask[tgt] = 1'b1;
              end
            end else if (wv[3:2] == 2'b11 && wv[0]) begin
              // Setting one of the missing direction bits 6 and 7.
              r.error_code = ERR_DIR_HIGH;
            end else if (bit_sel < 6 && dir_bits[bit_sel] != wv[0]) begin
              dir_bits[bit_sel] = wv[0];
              r.update_mask[bit_sel/2] = 1'b1;
            end
          end
          FORM_LOAD_DIR: begin
            diff = wv[5:0] ^ dir_bits;
            dir_bits = wv[5:0];
            r.update_mask = {|diff[5:4], |diff[3:2], |diff[1:0]};
          end
          default: r.error_code = ERR_BAD_FORM;
        endcase
      end
      default: ;
    endcase
    for (int n = 0; n < NumPorts; n++) begin
      en = nibble_mask(n);
      r.drive_value[n]  = (port_latch[n] & en) | (float_level[n] & ~en);
      r.drive_enable[n] = en;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one access, wait for its transfer, then record the expected result.
  // Valid is lowered only for an idle gap, never lowered and raised in one step.
  task automatic send_access(input action_e act, input logic [1:0] port,
                             input byte_t wv, input byte_t pins);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pins, wv};
    s_axis_tuser  <= {port, act};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_access_results.push_back(predict_port_access(act, port, wv, pins));
    accesses_sent++;
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_access_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Setup phase, access phase, then an idle gap before the next transfer.
  task automatic write_float_level(input int unsigned port, input byte_t level);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'((RegFloat0 + port) * RegStride);
    pwdata  <= {24'd0, level};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    float_level[port] = level;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle.
  task automatic set_float_levels(input byte_t l0, input byte_t l1, input byte_t l2);
    drain_results();
    write_float_level(0, l0);
    write_float_level(1, l1);
    write_float_level(2, l2);
  endtask

  // Mostly well-formed control writes with random content, some raw noise.
  task automatic send_random_access();
    action_e     act;
    logic [1:0]  port;
    byte_t       wv;
    int unsigned pick;
    act  = action_e'($urandom_range(3));
    port = ($urandom_range(9) == 0) ? NoPort : 2'($urandom_range(2));
    wv   = 8'($urandom_range(255));
    if (act == ACT_WRITE_CTRL) begin
      pick = $urandom_range(9);
      if (pick < 6)      wv[7:6] = FORM_BIT_OP;
      else if (pick < 8) wv[7:6] = FORM_LOAD_DIR;
    end
    send_access(act, port, wv, 8'($urandom_range(255)));
  endtask

  // Corners from reset: reads, direction loads, every bit-op form and error.
  task automatic test_directed_accesses();
    send_access(ACT_READ_CTRL, 2'd0, 8'h00, 8'h00);
    send_access(ACT_READ_DATA, 2'd0, 8'h00, 8'hff);
    send_access(ACT_READ_DATA, NoPort, 8'h00, 8'hff);
    send_access(ACT_WRITE_CTRL, 2'd0, 8'h3f, 8'h00);
    send_access(ACT_WRITE_DATA, 2'd0, 8'hff, 8'h00);
    send_access(ACT_WRITE_DATA, 2'd1, 8'ha5, 8'h00);
    send_access(ACT_WRITE_DATA, 2'd2, 8'hff, 8'h00);
    send_access(ACT_WRITE_DATA, NoPort, 8'hff, 8'h00);
    send_access(ACT_READ_DATA, 2'd1, 8'h00, 8'h00);
    send_access(ACT_WRITE_CTRL, 2'd0, 8'hee, 8'h00);   // clear latch 2 bit 7
    send_access(ACT_WRITE_CTRL, 2'd0, 8'hc0, 8'h00);   // clear latch 0 bit 0
    send_access(ACT_WRITE_CTRL, 2'd0, 8'hf0, 8'h00);   // clear direction bit 0
    send_access(ACT_WRITE_CTRL, 2'd0, 8'hfd, 8'h00);   // set direction bit 6
    send_access(ACT_WRITE_CTRL, 2'd0, 8'hfc, 8'h00);   // clear direction bit 6
    send_access(ACT_WRITE_CTRL, 2'd0, 8'hff, 8'h00);   // set direction bit 7
    send_access(ACT_WRITE_CTRL, 2'd0, 8'h40, 8'h00);
    send_access(ACT_WRITE_CTRL, 2'd0, 8'h80, 8'h00);
    send_access(ACT_WRITE_CTRL, 2'd0, 8'hb5, 8'h00);
    send_access(ACT_WRITE_CTRL, 2'd0, 8'h00, 8'h00);
    send_access(ACT_READ_DATA, 2'd2, 8'h00, 8'h5a);
    send_access(ACT_READ_CTRL, 2'd0, 8'h00, 8'h00);
    send_access(ACT_WRITE_DATA, 2'd1, 8'h00, 8'h00);
    send_access(ACT_WRITE_CTRL, 2'd0, 8'hfb, 8'h00);   // set direction bit 5
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random_access();
  endtask

  // Hold the output off for a long stretch while accesses keep coming, so the
  // block fills and stalls its input.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (40) send_random_access();
  endtask

  // Receiver: random ready, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    int unsigned base;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_access_results.size() == 0) begin
        $error("result transfer with no access outstanding: 0x%0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_access_results.pop_front();
        results_checked++;
        check_field("read_value", want.read_value, m_axis_tdata[7:0]);
        check_field("update_mask", want.update_mask, m_axis_tdata[10:8]);
        for (int n = 0; n < NumPorts; n++) begin
          base = 11 + 16 * n;
          check_field($sformatf("drive_value_%0d", n), want.drive_value[n],
                      m_axis_tdata[base +: 8]);
          check_field($sformatf("drive_enable_%0d", n), want.drive_enable[n],
                      m_axis_tdata[base + 8 +: 8]);
        end
        check_field("error_code", want.error_code, m_axis_tdata[60:59]);
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("nibble_direction_parallel_port_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int n = 0; n < NumPorts; n++) begin
      port_latch[n]  = '0;
      float_level[n] = '0;
    end
    dir_bits        = '0;
    send_idle_pct   = 12;
    recv_idle_pct   = 56;
    accesses_sent   = 0;
    results_checked = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    hold_left       = 0;
    hold_request    = 1'b0;

    // Hold reset, then release it at a clock edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_float_levels(8'hff, 8'hff, 8'hff);
    test_directed_accesses();
    set_float_levels(8'h00, 8'h00, 8'h00);
    test_random_traffic(700, 12, 56);
    set_float_levels(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    test_random_traffic(650, 56, 12);
    set_float_levels(8'ha5, 8'h5a, 8'h0f);
    test_random_traffic(650, 0, 0);
    set_float_levels(8'hff, 8'h00, 8'($urandom_range(255)));
    test_output_hold();
    drain_results();

    $display("Covered %0d accesses: directed corners, random traffic under three idle mixes",
             accesses_sent);
    $display("and a long output hold; %0d results checked across five float settings.",
             results_checked);
    if (mismatches == 0) begin
      $display("nibble_direction_parallel_port_unit test passed");
    end else begin
      $display("nibble_direction_parallel_port_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ndpp_pkg.sv
rtl/ndpp_regs.sv
rtl/ndpp_core.sv
rtl/nibble_direction_parallel_port_unit.sv
tb/tb.sv
